[design/s2dd_pkg.sv]
// ----------------------------------------------------------------------------
// s2dd_pkg
// Shared types and constants for the Steim-2 difference decoder.
// ----------------------------------------------------------------------------
package s2dd_pkg;

    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int COUNT_W  = 13;
    localparam int SAMPLE_W = 32;

    // map codes
    localparam logic [1:0] WC_SKIP  = 2'd0;
    localparam logic [1:0] WC_BYTES = 2'd1;
    localparam logic [1:0] WC_WIDE  = 2'd2;
    localparam logic [1:0] WC_NARROW = 2'd3;

    // sub-codes (top two bits of the data word)
    localparam logic [1:0] SC_0 = 2'd0;
    localparam logic [1:0] SC_1 = 2'd1;
    localparam logic [1:0] SC_2 = 2'd2;
    localparam logic [1:0] SC_3 = 2'd3;

    typedef enum logic [1:0] {
        K_SKIP,
        K_BAD,
        K_DIGITS
    } t_kind;

    typedef enum logic [1:0] {
        ST_SAMPLE  = 2'd0,
        ST_BADCODE = 2'd1,
        ST_SHORT   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIGITS,
        S_BAD,
        S_SHORT
    } t_state;

    // classified word, front to back
    typedef struct packed {
        logic                 first;
        logic [SAMPLE_W-1:0]  prev;
        logic [COUNT_W-1:0]   count;
        t_kind                kind;
        logic [31:0]          bits;   // digits left-aligned
        logic [4:0]           wid;    // digit width
        logic [4:0]           shamt;  // 32 - digit width
        logic [2:0]           ndig;   // digits in word
        logic                 last;
    } t_desc;

endpackage

[design/s2dd_front.sv]
// ----------------------------------------------------------------------------
// s2dd_front
// Classifies one compressed word: digit width, count and alignment.
// ----------------------------------------------------------------------------
module s2dd_front
    import s2dd_pkg::*;
(
    input  logic                       i_first_word,
    input  logic signed [SAMPLE_W-1:0] i_prev_sample,
    input  logic [COUNT_W-1:0]         i_sample_count,
    input  logic [1:0]                 i_word_code,
    input  logic [31:0]                i_data_word,
    input  logic                       i_last_word,
    output t_desc                      o_desc
);

    logic [1:0] w_top;

    assign w_top = i_data_word[31:30];

    always_comb begin
        o_desc       = '0;
        o_desc.first = i_first_word;
        o_desc.prev  = i_prev_sample;
        o_desc.count = i_sample_count;
        o_desc.last  = i_last_word;
        o_desc.kind  = K_DIGITS;
        // all packings but bytes and 4-bit leave two flag bits on top
        o_desc.bits  = i_data_word << 2;
        case (i_word_code)
            WC_SKIP: begin
                o_desc.kind = K_SKIP;
            end
            WC_BYTES: begin
                o_desc.bits  = i_data_word;
                o_desc.wid   = 5'd8;
                o_desc.shamt = 5'd24;
                o_desc.ndig  = 3'd4;
            end
            WC_WIDE: begin
                case (w_top)
                    SC_1: begin
                        o_desc.wid = 5'd30; o_desc.shamt = 5'd2;  o_desc.ndig = 3'd1;
                    end
                    SC_2: begin
                        o_desc.wid = 5'd15; o_desc.shamt = 5'd17; o_desc.ndig = 3'd2;
                    end
                    SC_3: begin
                        o_desc.wid = 5'd10; o_desc.shamt = 5'd22; o_desc.ndig = 3'd3;
                    end
                    default: begin
                        o_desc.kind = K_BAD;
                    end
                endcase
            end
            WC_NARROW: begin
                case (w_top)
                    SC_0: begin
                        o_desc.wid = 5'd6; o_desc.shamt = 5'd26; o_desc.ndig = 3'd5;
                    end
                    SC_1: begin
                        o_desc.wid = 5'd5; o_desc.shamt = 5'd27; o_desc.ndig = 3'd6;
                    end
                    SC_2: begin
                        o_desc.bits = i_data_word << 4;
                        o_desc.wid = 5'd4; o_desc.shamt = 5'd28; o_desc.ndig = 3'd7;
                    end
                    default: begin
                        o_desc.kind = K_BAD;
                    end
                endcase
            end
            default: begin
                o_desc.kind = K_SKIP;
            end
        endcase
    end

endmodule

[design/s2dd_queue.sv]
// ----------------------------------------------------------------------------
// s2dd_queue
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
module s2dd_queue
    import s2dd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_desc o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_desc          r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           w_wr, w_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[design/s2dd_back.sv]
// ----------------------------------------------------------------------------
// s2dd_back
// Expands classified words into samples, one result per cycle while the output
// register can take it, through an output register.
// ----------------------------------------------------------------------------
module s2dd_back
    import s2dd_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  t_desc                      i_desc,
    output logic                       o_take,
    output logic                       o_empty,
    input  logic                       i_pop,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output logic                       o_end_of_packet,
    output logic [1:0]                 o_status
);

    localparam int LW = $clog2(MAX_SAMPLES + 1);

    t_state              r_state, n_state;
    logic [LW-1:0]       r_left, n_left;
    logic [SAMPLE_W-1:0] r_sum, n_sum;
    logic [31:0]         r_bits, n_bits;
    logic [4:0]          r_wid, n_wid;
    logic [4:0]          r_shamt, n_shamt;
    logic [2:0]          r_ndig, n_ndig;
    logic                r_last, n_last;

    logic                r_out_valid, n_out_valid;
    logic [SAMPLE_W-1:0] r_out_sample, n_out_sample;
    logic                r_out_eop, n_out_eop;
    t_status             r_out_status, n_out_status;

    logic                w_out_ready, w_step, w_done;
    logic [SAMPLE_W-1:0] w_diff, w_sum_step;
    logic [LW-1:0]       w_left_step;
    logic [LW-1:0]       w_work_left, w_base_left, w_count_sat;
    logic [SAMPLE_W-1:0] w_work_sum, w_base_sum;

    assign w_out_ready = !r_out_valid || i_pop;
    assign w_step      = (r_state != S_IDLE) && w_out_ready;

    // digit sits left-aligned; arithmetic shift sign-extends it
    assign w_diff      = 32'($signed(r_bits) >>> r_shamt);
    assign w_sum_step  = r_sum + w_diff;
    assign w_left_step = r_left - 1'b1;

    assign w_count_sat = (32'(i_desc.count) > 32'(MAX_SAMPLES)) ? LW'(MAX_SAMPLES)
                                                                  : LW'(i_desc.count);

    // engine is free for the next word after this cycle
    always_comb begin
        w_done = 1'b0;
        case (r_state)
            S_IDLE:   w_done = 1'b1;
            S_DIGITS: w_done = w_step && ((w_left_step == '0) ||
                                          (r_ndig == 3'd1 && !r_last));
            S_BAD:    w_done = w_step;
            S_SHORT:  w_done = w_step;
            default:  w_done = 1'b1;
        endcase
    end

    assign o_take = w_done && i_valid;

    // state after this cycle's step, before a new word is loaded
    always_comb begin
        w_work_left = r_left;
        w_work_sum  = r_sum;
        if (w_step) begin
            case (r_state)
                S_DIGITS: begin
                    w_work_left = w_left_step;
                    w_work_sum  = w_sum_step;
                end
                S_BAD, S_SHORT: begin
                    w_work_left = '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign w_base_left = i_desc.first ? w_count_sat : w_work_left;
    assign w_base_sum  = i_desc.first ? i_desc.prev : w_work_sum;

    // next state
    always_comb begin
        n_state = r_state;
        if (w_step) begin
            case (r_state)
                S_DIGITS: begin
                    if (w_left_step == '0) begin
                        n_state = S_IDLE;
                    end else if (r_ndig == 3'd1) begin
                        n_state = r_last ? S_SHORT : S_IDLE;
                    end
                end
                S_BAD:   n_state = S_IDLE;
                S_SHORT: n_state = S_IDLE;
                default: n_state = S_IDLE;
            endcase
        end
        if (o_take) begin
            if (w_base_left == '0) begin
                n_state = S_IDLE;
            end else begin
                case (i_desc.kind)
                    K_BAD:    n_state = S_BAD;
                    K_DIGITS: n_state = S_DIGITS;
                    K_SKIP:   n_state = i_desc.last ? S_SHORT : S_IDLE;
                    default:  n_state = S_IDLE;
                endcase
            end
        end
    end

    // datapath and result register
    always_comb begin
        n_left       = w_work_left;
        n_sum        = w_work_sum;
        n_bits       = r_bits;
        n_wid        = r_wid;
        n_shamt      = r_shamt;
        n_ndig       = r_ndig;
        n_last       = r_last;
        n_out_valid  = r_out_valid && !i_pop;
        n_out_sample = r_out_sample;
        n_out_eop    = r_out_eop;
        n_out_status = r_out_status;
        if (w_step) begin
            n_out_valid = 1'b1;
            case (r_state)
                S_DIGITS: begin
                    n_out_sample = w_sum_step;
                    n_out_eop    = (w_left_step == '0);
                    n_out_status = ST_SAMPLE;
                    n_bits       = r_bits << r_wid;
                    n_ndig       = r_ndig - 1'b1;
                end
                S_BAD: begin
                    n_out_sample = '0;
                    n_out_eop    = 1'b1;
                    n_out_status = ST_BADCODE;
                end
                default: begin
                    n_out_sample = '0;
                    n_out_eop    = 1'b1;
                    n_out_status = ST_SHORT;
                end
            endcase
        end
        if (o_take) begin
            n_left  = w_base_left;
            n_sum   = w_base_sum;
            n_bits  = i_desc.bits;
            n_wid   = i_desc.wid;
            n_shamt = i_desc.shamt;
            n_ndig  = i_desc.ndig;
            n_last  = i_desc.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_left      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_left      <= n_left;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits       <= n_bits;
        r_wid        <= n_wid;
        r_shamt      <= n_shamt;
        r_ndig       <= n_ndig;
        r_last       <= n_last;
        r_out_sample <= n_out_sample;
        r_out_eop    <= n_out_eop;
        r_out_status <= n_out_status;
    end

    assign o_empty         = !r_out_valid;
    assign o_sample        = r_out_sample;
    assign o_end_of_packet = r_out_eop;
    assign o_status        = r_out_status;

`ifndef SYNTH
    // a busy engine always owes samples to an open packet
    a_busy_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_left != '0))
        else $error("engine busy with no samples owed");

    a_digits_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIGITS) |-> (r_ndig != 3'd0))
        else $error("digit state with no digits left");

    a_left_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_left) <= 32'(MAX_SAMPLES))
        else $error("sample count above maximum");

    // status results always close the packet
    a_status_eop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && (r_state == S_BAD || r_state == S_SHORT)) |=>
            (r_out_valid && r_out_eop))
        else $error("status result without end of packet");
`endif

endmodule

[design/steim2_difference_decoder_top.sv]
// ----------------------------------------------------------------------------
// steim2_difference_decoder_top
// Steim-2 word decoder: compressed words in, reconstructed samples out.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | push / full        | first_word prev_sample sample_count
//           |                    | word_code data_word last_word
//  result   | empty / pop        | sample end_of_packet status
//
//  One result leaves the back engine per cycle unless the result register
//  holds an unpopped item. Up to seven samples per word; the engine takes
//  the next word as it emits the last result of the current one.
//  A short queue of QUEUE_DEPTH words decouples input from the engine.
//  Reset is synchronous, active low; it clears queue, engine and result flag.
//  The engine stalls only while the result register holds an unpopped item.
// ----------------------------------------------------------------------------
module steim2_difference_decoder_top
    import s2dd_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       i_first_word,
    input  logic signed [SAMPLE_W-1:0] i_prev_sample,
    input  logic [COUNT_W-1:0]         i_sample_count,
    input  logic [1:0]                 i_word_code,
    input  logic [31:0]                i_data_word,
    input  logic                       i_last_word,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output logic                       o_end_of_packet,
    output logic [1:0]                 o_status
);

    t_desc w_front_desc;
    t_desc w_q_desc;
    logic  w_q_valid;
    logic  w_take;

    s2dd_front u_front (
        .i_first_word   (i_first_word),
        .i_prev_sample  (i_prev_sample),
        .i_sample_count (i_sample_count),
        .i_word_code    (i_word_code),
        .i_data_word    (i_data_word),
        .i_last_word    (i_last_word),
        .o_desc         (w_front_desc)
    );

    s2dd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_front_desc),
        .o_full  (full),
        .i_pop   (w_take),
        .o_valid (w_q_valid),
        .o_data  (w_q_desc)
    );

    s2dd_back #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_q_valid),
        .i_desc          (w_q_desc),
        .o_take          (w_take),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_sample        (o_sample),
        .o_end_of_packet (o_end_of_packet),
        .o_status        (o_status)
    );

endmodule
